>>> rtl/motion_wake_detector_defines.svh
// ----------------------------------------------------------------------------
// Motion wake detector assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MOTION_WAKE_DETECTOR_DEFINES_SVH
`define MOTION_WAKE_DETECTOR_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MWD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MWD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mwd_pkg.sv
// ----------------------------------------------------------------------------
// Motion wake detector package
// Shared types, register indexes and constants of the wake detector.
// ----------------------------------------------------------------------------
package mwd_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_WAKE_DURATION  = 3'd0;
    localparam logic [2:0] CFG_SLEEP_DURATION = 3'd1;
    localparam logic [2:0] CFG_HOLD_ACTIVE    = 3'd2;
    localparam logic [2:0] CFG_DIAGNOSE_MODE  = 3'd3;
    localparam logic [2:0] CFG_ALARM_THRESH   = 3'd4;
    localparam logic [2:0] CFG_ALARM_INDEP    = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Command codes carried in the input tuser
    localparam logic CMD_MOTION = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Time constants
    localparam int MS_PER_S     = 1000;
    localparam int DIAG_HOLD_MS = 1000;
    localparam int SLEEP_MS_W   = 26;

    // Configuration as held by the register block, with derived values
    typedef struct packed {
        logic [15:0]           wake_ms;
        logic [SLEEP_MS_W-1:0] sleep_ms;
        logic                  hold_active;
        logic                  diagnose_mode;
        logic [9:0]            alarm_threshold;
        logic [19:0]           threshold_sq;
        logic                  alarm_independent;
    } cfg_t;

    // One input transaction
    typedef struct packed {
        logic        command;
        logic        suppress_expired;
        logic        read_ok;
        logic [19:0] motion_mag;
        logic [31:0] now_ms;
    } in_item_t;

    // One result transaction, last field in the lowest bits
    typedef struct packed {
        logic       diag_indicator;
        logic       alarm_latched;
        logic       fence_check;
        logic       alarm_raise;
        logic       tracking_request;
        logic [1:0] wake_phase;
    } out_item_t;

endpackage

>>> rtl/motion_wake_detector.sv
// ----------------------------------------------------------------------------
// Motion wake detector
// Qualifies motion interrupts and time ticks into a wake phase, a tracking
// request and motion alarm outputs.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Content
//  s_axis    in         s_axis_tvalid/tready       command, time, magnitude
//  m_axis    out        m_axis_tvalid/tready       phase and flags
//  cfg       in         cfg_we, no back-pressure   register index and value
//
// One transaction is accepted per cycle while the result is not stalled; it
// passes first into the input register, then through the state update into
// the result register, whose state loop sets the rate.
// Reset puts the phase to active with tracking requested; there is no
// clearing pass. A stalled result holds while the input register still takes
// one further transaction.
// ----------------------------------------------------------------------------
module motion_wake_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ms[31:0], motion_mag[51:32], read_ok[52], suppress_expired[53], zero[55:54]
    input  logic [55:0]                      s_axis_tdata,
    // command[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // wake_phase[1:0], tracking_request[2], alarm_raise[3], fence_check[4],
    // alarm_latched[5], diag_indicator[6], zero[7]
    output logic [7:0]                       m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [mwd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mwd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import mwd_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item;
    in_item_t  item;
    logic      item_valid;
    logic      item_take;
    out_item_t out_item;

    // Unpack the input transaction
    assign in_item.command          = s_axis_tuser;
    assign in_item.now_ms           = s_axis_tdata[31:0];
    assign in_item.motion_mag       = s_axis_tdata[51:32];
    assign in_item.read_ok          = s_axis_tdata[52];
    assign in_item.suppress_expired = s_axis_tdata[53];

    mwd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mwd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    mwd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (out_item)
    );

    // Pack the result transaction
    assign m_axis_tdata = {1'b0, out_item};

endmodule

>>> rtl/mwd_cfg.sv
// ----------------------------------------------------------------------------
// Motion wake detector configuration registers
// Holds the register file and works out the sleep time in milliseconds and
// the squared alarm threshold when they are written.
// ----------------------------------------------------------------------------
module mwd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mwd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mwd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output mwd_pkg::cfg_t                    cfg
);
    import mwd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic [9:0] thresh_w;

    assign thresh_w = cfg_wdata[9:0];

    // Register decode, derived values computed at write time
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WAKE_DURATION:  cfg_next.wake_ms = cfg_wdata;
                CFG_SLEEP_DURATION: cfg_next.sleep_ms =
                    SLEEP_MS_W'(cfg_wdata) * SLEEP_MS_W'(MS_PER_S);
                CFG_HOLD_ACTIVE:    cfg_next.hold_active = cfg_wdata[0];
                CFG_DIAGNOSE_MODE:  cfg_next.diagnose_mode = cfg_wdata[0];
                CFG_ALARM_THRESH:
                begin
                    cfg_next.alarm_threshold = thresh_w;
                    cfg_next.threshold_sq    = 20'(thresh_w) * 20'(thresh_w);
                end
                CFG_ALARM_INDEP:    cfg_next.alarm_independent = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/mwd_in_stage.sv
// ----------------------------------------------------------------------------
// Motion wake detector input stage
// Registers one input transaction and hands it on when the core takes it.
// ----------------------------------------------------------------------------
module mwd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mwd_pkg::in_item_t in_item,
    output logic              item_valid,
    input  logic              item_take,
    output mwd_pkg::in_item_t item
);
    import mwd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The stage refills in the same cycle as the core empties it.
    assign in_ready = !valid_reg || item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/mwd_core.sv
// ----------------------------------------------------------------------------
// Motion wake detector core
// Updates the wake phase, start time and flags for one transaction per cycle
// while the result is not stalled, and registers the result.
// ----------------------------------------------------------------------------
`include "motion_wake_detector_defines.svh"

module mwd_core (
    input  logic               clk,
    input  logic               rst_n,
    input  mwd_pkg::cfg_t      cfg,
    input  logic               item_valid,
    output logic               item_take,
    input  mwd_pkg::in_item_t  item,
    output logic               out_valid,
    input  logic               out_ready,
    output mwd_pkg::out_item_t out_item
);
    import mwd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_QUAL   = 2'd1,
        PH_ACTIVE = 2'd2
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic        tracking_reg;
    logic        tracking_next;
    logic        alarm_reg;
    logic        alarm_next;
    logic        indicator_reg;
    logic        indicator_next;
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic [31:0] elapsed;
    logic        raise;
    logic        fence;

    // Take an item whenever the result register is free or being emptied.
    assign item_take = item_valid && (!out_valid_reg || out_ready);
    assign elapsed   = item.now_ms - start_reg;

    // Next state for the current item
    always_comb
    begin
        phase_next     = phase_reg;
        start_next     = start_reg;
        tracking_next  = tracking_reg;
        alarm_next     = alarm_reg;
        indicator_next = indicator_reg;
        raise          = 1'b0;
        fence          = 1'b0;

        if (item.command == CMD_MOTION)
        begin
            if (cfg.diagnose_mode)
            begin
                start_next     = item.now_ms;
                indicator_next = 1'b1;
                phase_next     = PH_ACTIVE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        start_next = item.now_ms;
                        phase_next = PH_QUAL;
                    end
                    PH_QUAL:
                    begin
                        if (elapsed >= {16'd0, cfg.wake_ms})
                        begin
                            phase_next    = PH_ACTIVE;
                            tracking_next = 1'b1;
                        end
                    end
                    PH_ACTIVE:
                    begin
                        start_next = item.now_ms;
                    end
                    default:
                    begin
                        start_next = item.now_ms;
                    end
                endcase

                // Alarm check: set against the squared threshold, clear
                // against the plain one.
                if (item.read_ok && (cfg.alarm_threshold != 10'd0))
                begin
                    if ((item.motion_mag >= cfg.threshold_sq) && item.suppress_expired)
                    begin
                        alarm_next = 1'b1;
                        raise      = cfg.alarm_independent;
                        fence      = !cfg.alarm_independent;
                    end
                    else if ((item.motion_mag < {10'd0, cfg.alarm_threshold})
                             && item.suppress_expired)
                    begin
                        alarm_next = 1'b0;
                    end
                end
            end
        end
        else
        begin
            if (cfg.diagnose_mode)
            begin
                if ((phase_reg == PH_ACTIVE) && (elapsed > 32'(DIAG_HOLD_MS)))
                begin
                    indicator_next = 1'b0;
                    phase_next     = PH_IDLE;
                end
            end
            else if ((phase_reg == PH_ACTIVE) && !cfg.hold_active)
            begin
                if (elapsed >= {{(32 - SLEEP_MS_W){1'b0}}, cfg.sleep_ms})
                begin
                    phase_next    = PH_IDLE;
                    tracking_next = 1'b0;
                end
            end
        end
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ACTIVE;
            start_reg     <= '0;
            tracking_reg  <= 1'b1;
            alarm_reg     <= 1'b0;
            indicator_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            if (item_take)
            begin
                phase_reg                     <= phase_next;
                start_reg                     <= start_next;
                tracking_reg                  <= tracking_next;
                alarm_reg                     <= alarm_next;
                indicator_reg                 <= indicator_next;
                out_valid_reg                 <= 1'b1;
                out_item_reg.wake_phase       <= phase_next;
                out_item_reg.tracking_request <= tracking_next;
                out_item_reg.alarm_raise      <= raise;
                out_item_reg.fence_check      <= fence;
                out_item_reg.alarm_latched    <= alarm_next;
                out_item_reg.diag_indicator   <= indicator_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Checks on the core's own behaviour
    `MWD_ASSERT_IMP(a_phase_code, out_valid_reg, out_item_reg.wake_phase != 2'd3,
        "unused phase code in result")
    `MWD_ASSERT_IMP(a_raise_latched, out_valid_reg && out_item_reg.alarm_raise,
        out_item_reg.alarm_latched && !out_item_reg.fence_check,
        "alarm raised without latched flag or together with fence check")
    `MWD_ASSERT_IMP(a_fence_latched, out_valid_reg && out_item_reg.fence_check,
        out_item_reg.alarm_latched, "fence check without latched alarm flag")
    `MWD_ASSERT_NXT(a_take_result, item_take, out_valid_reg,
        "taken transaction gave no result")

endmodule
